// ===== rtl/soc_pkg.sv =====
// shared types and constants for the speech offset compensation filter
package soc_pkg;

    // sample and coefficient widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 15;
    localparam int FRAC_W   = 15;
    // filter state in signed Q.15
    localparam int STATE_W  = 32;
    // window position counter covers windows up to 512 samples
    localparam int POS_W    = 9;

    // default window geometry
    localparam int FRAME_LENGTH_DEF  = 240;
    localparam int WINDOW_LENGTH_DEF = 280;

    // reset value of the pole coefficient, about 0.999 in Q0.15
    localparam logic [COEF_W-1:0] POLE_COEF_RESET = 15'd32735;

    // window markers for the current sample
    typedef struct packed {
        logic frame_end;
        logic window_end;
    } t_win_flags;

endpackage

// ===== rtl/soc_window_ctl.sv =====
// window position counter with frame end and window end markers
module soc_window_ctl
    import soc_pkg::*;
#(
    parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    output t_win_flags o_flags
);

    localparam logic [POS_W-1:0] FRAME_LAST  = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] WINDOW_LAST = POS_W'(WINDOW_LENGTH - 1);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    // markers for the sample being filtered now
    assign o_flags.frame_end  = (r_pos == FRAME_LAST);
    assign o_flags.window_end = (r_pos >= WINDOW_LAST);

    // wrap to the window start after the last window sample
    always_comb begin
        n_pos = r_pos;
        if (i_step) begin
            if (o_flags.window_end) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // position never runs past the last window sample
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= WINDOW_LAST)
        else $error("window position beyond window end");

    // a window end transfer restarts the window
    a_pos_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_flags.window_end) |=> (r_pos == '0))
        else $error("window position did not wrap");

endmodule

// ===== rtl/soc_filter_dp.sv =====
// high-pass recurrence, saturation, integer output and window state restore
module soc_filter_dp
    import soc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [COEF_W-1:0]   i_pole_coefficient,
    input  t_win_flags                 i_flags,
    output logic signed [SAMPLE_W-1:0] o_filtered_sample
);

    localparam int SUM_W  = STATE_W + 3;
    localparam int PROD_W = STATE_W + COEF_W + 1;
    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'(32767) <<< FRAC_W;
    localparam logic signed [SUM_W-1:0] Y_MIN = -(SUM_W'(32768) <<< FRAC_W);

    logic signed [SAMPLE_W-1:0] r_prev_input;
    logic signed [STATE_W-1:0]  r_prev_output;
    logic signed [SAMPLE_W-1:0] r_saved_input;
    logic signed [SAMPLE_W-1:0] r_saved_output;
    logic signed [SAMPLE_W-1:0] n_prev_input;
    logic signed [STATE_W-1:0]  n_prev_output;
    logic signed [SAMPLE_W-1:0] n_saved_input;
    logic signed [SAMPLE_W-1:0] n_saved_output;

    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    x_half;
    logic signed [SUM_W-1:0]    px_half;
    logic signed [SUM_W-1:0]    feedback;
    logic signed [SUM_W-1:0]    y_sum;
    logic signed [STATE_W-1:0]  y_sat;
    logic                       neg_frac;

    // alpha * y_prev, floored back to Q.15 by the arithmetic drop of low bits
    assign prod     = $signed({1'b0, i_pole_coefficient}) * r_prev_output;
    assign feedback = {{(SUM_W - (PROD_W - FRAC_W)){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};

    // x/2 and x_prev/2 exactly in Q.15
    assign x_half  = {{(SUM_W - SAMPLE_W - FRAC_W + 1){i_sample[SAMPLE_W-1]}},
                      i_sample, {(FRAC_W - 1){1'b0}}};
    assign px_half = {{(SUM_W - SAMPLE_W - FRAC_W + 1){r_prev_input[SAMPLE_W-1]}},
                      r_prev_input, {(FRAC_W - 1){1'b0}}};

    assign y_sum = x_half - px_half + feedback;

    // clamp to the 16-bit integer range
    always_comb begin
        priority if (y_sum > Y_MAX) begin
            y_sat = STATE_W'(Y_MAX);
        end else if (y_sum < Y_MIN) begin
            y_sat = STATE_W'(Y_MIN);
        end else begin
            y_sat = y_sum[STATE_W-1:0];
        end
    end

    // truncate toward zero: floor, plus one for a negative value with a fraction
    assign neg_frac          = y_sat[STATE_W-1] && (y_sat[FRAC_W-1:0] != '0);
    assign o_filtered_sample = y_sat[FRAC_W+SAMPLE_W-1:FRAC_W] + SAMPLE_W'(neg_frac);

    // state update, frame end copy first, then window end restore
    always_comb begin
        n_prev_input   = r_prev_input;
        n_prev_output  = r_prev_output;
        n_saved_input  = r_saved_input;
        n_saved_output = r_saved_output;
        if (i_step) begin
            n_prev_input  = i_sample;
            n_prev_output = y_sat;
            if (i_flags.frame_end) begin
                n_saved_input  = i_sample;
                n_saved_output = o_filtered_sample;
            end
            if (i_flags.window_end) begin
                n_prev_input  = n_saved_input;
                n_prev_output = {{(STATE_W - SAMPLE_W - FRAC_W){n_saved_output[SAMPLE_W-1]}},
                                 n_saved_output, {FRAC_W{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_input   <= '0;
            r_prev_output  <= '0;
            r_saved_input  <= '0;
            r_saved_output <= '0;
        end else begin
            r_prev_input   <= n_prev_input;
            r_prev_output  <= n_prev_output;
            r_saved_input  <= n_saved_input;
            r_saved_output <= n_saved_output;
        end
    end

    // after a window end the recurrence restarts from the saved frame end values
    a_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_flags.window_end) |=>
            (r_prev_input == r_saved_input) &&
            (r_prev_output[STATE_W-1:FRAC_W] ==
                {{(STATE_W - SAMPLE_W - FRAC_W){r_saved_output[SAMPLE_W-1]}}, r_saved_output}))
        else $error("filter state not restored at window end");

endmodule

// ===== rtl/speech_offset_compensation_filter_core.sv =====
// top level of the speech offset compensation filter
//
// First-order DC removal high-pass filter over 16-bit speech samples.
// Input channel: i_valid / o_ready with i_sample. Output channel:
// o_valid / i_ready with o_filtered_sample and o_window_end, which marks
// the last sample of each analysis window (frame plus look-ahead).
// The pole coefficient is written through i_cfg_wr_en / i_cfg_wr_data,
// and the user must do so only while the block is idle; the block itself
// does not enforce this. Reset loads 32735 (about 0.999 in Q0.15).
// A transferred sample waits in the input register, is filtered into the
// result register once that register is free or being read, and is then
// offered on the output while a new sample can already be taken in.
// Throughput: one sample per cycle while i_ready is high; the multiply,
// add and saturate of the recurrence are combinational between the registers.
// At reset both registers empty, the filter state and the window position
// clear to zero. When the receiver stalls, the result register holds and
// one more sample can still wait in the input register; o_ready drops
// only once both are full.
module speech_offset_compensation_filter_core
    import soc_pkg::*;
#(
    parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_filtered_sample,
    output logic                       o_window_end,
    input  logic                       i_cfg_wr_en,
    input  logic        [COEF_W-1:0]   i_cfg_wr_data
);

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_in_sample;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_window_end;
    logic [COEF_W-1:0]          r_pole_coefficient;
    logic                       advance;
    logic                       step;
    logic                       in_xfer;
    logic signed [SAMPLE_W-1:0] y_int;
    t_win_flags                 flags;

    // handshake control
    assign advance = !r_out_valid || i_ready;
    assign step    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_window_end      = r_out_window_end;

    // pole coefficient register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_coefficient <= POLE_COEF_RESET;
        end else if (i_cfg_wr_en) begin
            r_pole_coefficient <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_sample <= i_sample;
        end
    end

    // window position and markers
    soc_window_ctl #(
        .FRAME_LENGTH  (FRAME_LENGTH),
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_flags (flags)
    );

    // filter arithmetic and state
    soc_filter_dp u_filter_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_sample           (r_in_sample),
        .i_pole_coefficient (r_pole_coefficient),
        .i_flags            (flags),
        .o_filtered_sample  (y_int)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_sample     <= y_int;
            r_out_window_end <= flags.window_end;
        end
    end

    // a filtered sample always lands in the result register
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("filtered sample lost");

    // a held sample blocks new transfers only while the result is stalled
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !o_ready)
        else $error("input accepted while both registers are full");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid && $stable(r_out_sample))
        else $error("stalled result changed");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the speech offset compensation filter core
module testbench;
    import soc_pkg::*;

    localparam int FRAME_LEN   = FRAME_LENGTH_DEF;
    localparam int WINDOW_LEN  = WINDOW_LENGTH_DEF;
    localparam int Q15_ONE     = 32768;
    localparam longint Y_MAX   = longint'(32767) * Q15_ONE;
    localparam longint Y_MIN   = longint'(-32768) * Q15_ONE;
    localparam int IDLE_LIMIT  = 1000;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} t_ready_mode;
    typedef enum int {SRC_NOISE, SRC_WALK, SRC_DC, SRC_EXTREME} t_src_kind;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       window_end;
    } t_filt_result;

    // dut ports, all inputs known from time zero
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_filtered_sample;
    logic                       o_window_end;
    logic                       i_cfg_wr_en = 1'b0;
    logic [COEF_W-1:0]          i_cfg_wr_data = '0;

    // filter state mirrored by the predictor
    logic [COEF_W-1:0]          pole_coef = POLE_COEF_RESET;
    logic signed [SAMPLE_W-1:0] last_input = '0;
    logic signed [STATE_W-1:0]  last_output = '0;
    logic [POS_W-1:0]           win_pos = '0;
    logic signed [SAMPLE_W-1:0] frame_input = '0;
    logic signed [SAMPLE_W-1:0] frame_output = '0;

    // stimulus and scoreboard bookkeeping
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_filt_result               expected_results [$];
    int                         queued_count = 0;
    int                         accepted_count = 0;
    int                         results_checked = 0;
    int                         error_count = 0;
    int                         idle_cycles = 0;
    logic                       in_xfer = 1'b0;

    // sender and receiver pacing
    int                         burst_left = 1;
    int                         gap_left = 0;
    int                         max_gap = 0;
    t_ready_mode                ready_mode = READY_ALWAYS;
    logic [7:0]                 ready_pattern = 8'hff;
    logic [2:0]                 pattern_step = '0;
    int                         hold_left = 0;
    int                         holds_requested = 0;
    int                         holds_served = 0;

    int corner_samples [24] = '{0, 32767, -32768, 32767, -32768, -32768, -32768, -32768,
                                32767, 32767, 32767, 1, -1, 0, 21845, -21846,
                                12345, -12345, 256, -256, 16384, -16384, 32767, 0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    speech_offset_compensation_filter_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_window_end      (o_window_end),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data)
    );

    // one step of the dc removal recurrence, advancing the mirrored state
    function automatic t_filt_result filter_step(input logic signed [SAMPLE_W-1:0] x);
        longint                     feedback;
        longint                     y;
        logic signed [SAMPLE_W-1:0] y_int;
        t_filt_result               res;
        // alpha * y_prev in Q.30, floored back to Q.15
        feedback = (longint'(pole_coef) * longint'(last_output)) >>> FRAC_W;
        y = longint'(x) * (Q15_ONE / 2) - longint'(last_input) * (Q15_ONE / 2) + feedback;
        if (y > Y_MAX) begin
            y = Y_MAX;
        end else if (y < Y_MIN) begin
            y = Y_MIN;
        end
        // division truncates toward zero
        y_int = SAMPLE_W'(y / Q15_ONE);
        last_input = x;
        last_output = STATE_W'(y);
        // save state at the last frame sample
        if (win_pos == POS_W'(FRAME_LEN - 1)) begin
            frame_input = x;
            frame_output = y_int;
        end
        res.sample = y_int;
        res.window_end = (win_pos >= POS_W'(WINDOW_LEN - 1));
        // restore to the frame end so the look-ahead is filtered again
        if (res.window_end) begin
            last_input = frame_input;
            last_output = STATE_W'(longint'(frame_output) * Q15_ONE);
            win_pos = '0;
        end else begin
            win_pos = win_pos + 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 what, results_checked, got, want);
        error_count++;
    endtask

    // check output transfers, then predict for input transfers
    always @(posedge i_clk) begin
        t_filt_result want;
        in_xfer <= i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_filtered_sample, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_filtered_sample !== want.sample) begin
                    report_mismatch("filtered_sample", o_filtered_sample, want.sample);
                end
                if (o_window_end !== want.window_end) begin
                    report_mismatch("window_end", o_window_end, want.window_end);
                end
            end
            results_checked++;
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(filter_step(i_sample));
            accepted_count <= accepted_count + 1;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < IDLE_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sample driver, bursts separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_xfer) begin
            // offered sample waits for its transfer
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_samples.size() > 0) begin
            i_valid <= 1'b1;
            i_sample <= pending_samples.pop_front();
            if (burst_left > 1) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(1, 32);
                if (max_gap == 0 || $urandom_range(0, 2) == 0) begin
                    gap_left <= 0;
                end else begin
                    gap_left <= $urandom_range(1, max_gap);
                end
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result receiver with its own stall pattern and long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            i_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            pattern_step <= pattern_step + 1'b1;
            case (ready_mode)
                READY_ALWAYS: begin
                    i_ready <= 1'b1;
                end
                READY_RANDOM: begin
                    i_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_ready <= ready_pattern[pattern_step];
                end
            endcase
        end
    end

    task automatic queue_sample(input int x);
        pending_samples.push_back(SAMPLE_W'(x));
        queued_count++;
    endtask

    // speech-like segments: noise, slow walks, dc offsets and rail hits
    task automatic queue_speech(input int count);
        int        level;
        int        x;
        int        left;
        t_src_kind kind;
        level = 0;
        left = 0;
        kind = SRC_NOISE;
        x = 0;
        for (int n = 0; n < count; n++) begin
            if (left == 0) begin
                kind = t_src_kind'($urandom_range(0, 3));
                left = $urandom_range(4, 40);
                level = int'($urandom_range(0, 65535)) - 32768;
            end
            case (kind)
                SRC_NOISE: begin
                    x = int'($urandom_range(0, 65535)) - 32768;
                end
                SRC_WALK: begin
                    x = level + int'($urandom_range(0, 4096)) - 2048;
                end
                SRC_DC: begin
                    x = level + int'($urandom_range(0, 64)) - 32;
                end
                default: begin
                    x = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                end
            endcase
            if (x > 32767) begin
                x = 32767;
            end else if (x < -32768) begin
                x = -32768;
            end
            if (kind == SRC_WALK) begin
                level = x;
            end
            queue_sample(x);
            left--;
        end
    endtask

    task automatic write_pole(input logic [COEF_W-1:0] coef);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= coef;
        pole_coef = coef;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // every queued sample transferred and every result checked
    task automatic wait_idle();
        do @(negedge i_clk);
        while (accepted_count != queued_count || expected_results.size() != 0);
    endtask

    task automatic run_phase(input logic [COEF_W-1:0] coef, input int items,
                             input t_ready_mode mode, input int gap_limit,
                             input bit long_hold);
        write_pole(coef);
        ready_mode = mode;
        max_gap = gap_limit;
        ready_pattern = 8'($urandom_range(1, 255)) | 8'h01;
        if (long_hold) begin
            holds_requested++;
        end
        queue_speech(items);
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner samples with the largest pole
        write_pole(15'd32767);
        ready_mode = READY_ALWAYS;
        max_gap = 0;
        foreach (corner_samples[k]) begin
            queue_sample(corner_samples[k]);
        end
        wait_idle();

        // random phases across coefficient settings and pacing styles
        run_phase(15'd0, 130, READY_RANDOM, 6, 1'b0);
        run_phase(COEF_W'($urandom_range(0, 32767)), 130, READY_PATTERN, 3, 1'b1);
        run_phase(POLE_COEF_RESET, 140, READY_ALWAYS, 0, 1'b0);
        run_phase(15'd1, 130, READY_RANDOM, 10, 1'b1);
        run_phase(COEF_W'($urandom_range(0, 32767)), 130, READY_PATTERN, 6, 1'b0);
        run_phase(15'd32767, 130, READY_RANDOM, 2, 1'b0);

        // drain time for anything the block might still emit
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== speech_offset_compensation_filter_core.f =====
rtl/soc_pkg.sv
rtl/soc_window_ctl.sv
rtl/soc_filter_dp.sv
rtl/speech_offset_compensation_filter_core.sv
test/testbench.sv
